FILE: rtl/core/bsws_pkg.sv
// Package with the shared types and constants of the bounded stack with search.
package bsws_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int WORD_W      = 32;

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_PEEK   = 2'd2,
        OP_SEARCH = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_SRCH,
        S_DONE
    } t_state;

    typedef struct packed {
        t_op                op;
        logic signed [31:0] value;
    } t_in;

    typedef struct packed {
        t_status            status;
        logic signed [31:0] word_out;
        logic [3:0]         position;
        logic               is_empty;
        logic [4:0]         fill_count;
    } t_out;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [WORD_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

endpackage

FILE: rtl/core/bsws_ram.sv
// Generic single write port RAM with one registered read port.
module bsws_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/bsws_seq.sv
// Sequencer of the stack: fill count, memory addressing and the shared key compare.
module bsws_seq import bsws_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in               i_in_data,
    output t_ram_req          o_ram_req,
    input  logic [WORD_W-1:0] i_rd_data,
    output logic              o_res_valid,
    output t_out              o_res,
    input  logic              i_res_take
);

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count;
    t_op               r_op;
    logic [WORD_W-1:0] r_key;
    logic [ADDR_W-1:0] r_pos;
    t_status           r_status;
    logic [WORD_W-1:0] r_word;

    logic              accept;
    logic              full;
    logic              empty;
    logic [ADDR_W-1:0] top_addr;
    logic              match;
    logic              last;

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign full     = (r_count == CNT_W'(STACK_DEPTH));
    assign empty    = (r_count == '0);
    assign top_addr = ADDR_W'(r_count - CNT_W'(1));
    // The single comparator is reused for every entry that a search visits.
    assign match    = (i_rd_data == r_key);
    assign last     = (r_pos == top_addr);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_in_data.op)
                        OP_PUSH:         n_state = S_DONE;
                        OP_POP, OP_PEEK: n_state = empty ? S_DONE : S_LOAD;
                        OP_SEARCH:       n_state = empty ? S_DONE : S_SRCH;
                        default:         n_state = S_DONE;
                    endcase
                end
            end
            S_LOAD: n_state = S_DONE;
            S_SRCH: begin
                if (match || last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall      = (r_state != S_IDLE);
        o_ram_req.we    = accept && (i_in_data.op == OP_PUSH) && !full;
        o_ram_req.waddr = r_count[ADDR_W-1:0];
        o_ram_req.wdata = i_in_data.value;
        case (r_state)
            S_SRCH:  o_ram_req.raddr = top_addr - r_pos - ADDR_W'(1);
            default: o_ram_req.raddr = top_addr;
        endcase
        o_res_valid         = (r_state == S_DONE);
        o_res.status        = r_status;
        o_res.word_out      = r_word;
        o_res.position      = 4'(r_pos);
        o_res.is_empty      = empty;
        o_res.fill_count    = 5'(r_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                if ((i_in_data.op == OP_PUSH) && !full) begin
                    r_count <= r_count + CNT_W'(1);
                end else if ((i_in_data.op == OP_POP) && !empty) begin
                    r_count <= r_count - CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_op   <= i_in_data.op;
                    r_key  <= i_in_data.value;
                    r_pos  <= '0;
                    r_word <= '0;
                    case (i_in_data.op)
                        OP_PUSH:         r_status <= full ? ST_FULL : ST_OK;
                        OP_POP, OP_PEEK: r_status <= empty ? ST_EMPTY : ST_OK;
                        OP_SEARCH:       r_status <= empty ? ST_NOTFOUND : ST_OK;
                        default:         r_status <= ST_OK;
                    endcase
                end
            end
            S_LOAD: begin
                if (r_op != OP_SEARCH) begin
                    r_word <= i_rd_data;
                end
            end
            S_SRCH: begin
                if (!match) begin
                    if (last) begin
                        r_status <= ST_NOTFOUND;
                        r_pos    <= '0;
                    end else begin
                        r_pos <= r_pos + ADDR_W'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

endmodule

FILE: rtl/core/bounded_stack_with_search.sv
// Top level of the bounded stack with search: memory, sequencer and output register.
//
//  Channel | Direction | Handshake              | Payload
//  input   | in        | i_in_valid, o_in_stall | i_in_data  (t_in: op, value)
//  output  | out       | o_out_valid, i_out_stall | o_out_data (t_out)
//
// A push, or any request refused on a full or empty stack, goes straight to its
// result. A pop or peek first loads the top word through the registered read
// port of the entry memory. A search compares the entries from the top down, one
// per cycle through that read port, until a match or the bottom entry.
// Reset clears the fill count and the control state; the entries are not cleared
// and are never read before they are written.
// A stall on the output side holds the result in the output register; the next
// result waits in the sequencer, which then refuses new transactions.
module bounded_stack_with_search import bsws_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    t_ram_req          ram_req;
    logic [WORD_W-1:0] rd_data;
    logic              res_valid;
    t_out              res;
    logic              res_take;

    logic              r_out_valid;
    t_out              r_out_data;

    // The entries live in a plain RAM; the sequencer owns both of its ports.
    bsws_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_raddr (ram_req.raddr),
        .o_rdata (rd_data)
    );

    bsws_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_ram_req   (ram_req),
        .i_rd_data   (rd_data),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_take  (res_take)
    );

    // The output register is free when it is empty or its transaction completes now.
    assign res_take = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_take) begin
            r_out_data <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

FILE: rtl/core/bsws_chk.sv
// Port level checker for the bounded stack with search, with its bind statement.
module bsws_chk import bsws_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_stall,
    input logic o_out_valid,
    input logic i_out_stall,
    input t_out o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("output transaction changed while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second transaction accepted while the first is in work");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.is_empty == (o_out_data.fill_count == 5'd0)
                         || CNT_W > 5))
        else $error("empty flag disagrees with the fill count");

    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status == ST_EMPTY) |->
            o_out_data.is_empty && (o_out_data.word_out == 32'sd0))
        else $error("empty status on a stack that holds entries");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status == ST_FULL) |->
            o_out_data.fill_count == 5'(STACK_DEPTH))
        else $error("full status on a stack that is not full");

endmodule

bind bounded_stack_with_search bsws_chk u_chk (.*);

FILE: test/bounded_stack_with_search_test.sv
// Self-checking testbench for the bounded stack with search, with its scoreboard.
`timescale 1ns / 1ps

module bounded_stack_with_search_test import bsws_pkg::*;;

    // Random requests after the directed opening, and the length of the
    // output hold-off that forces the block to refuse new transactions.
    localparam int unsigned RANDOM_ITEMS   = 680;
    localparam int unsigned BACKLOG_CYCLES = 200;
    localparam int unsigned BACKLOG_ITEMS  = 24;

    // The scoreboard keeps its own image of the stack. Each accepted request
    // updates that image and queues the result the block must produce.
    class stack_scoreboard;
        logic [31:0] stack_image [STACK_DEPTH];
        int unsigned stack_fill;
        t_out        pending_results [$];
        int unsigned error_count;
        int unsigned result_count;
        int unsigned op_count [4];
        int unsigned full_refusals;
        int unsigned empty_refusals;
        int unsigned search_hits;
        int unsigned search_misses;

        function void note_request(t_in req);
            t_out        want;
            int unsigned d;
            bit          found;
            want        = '0;
            want.status = ST_OK;
            found       = 1'b0;
            op_count[req.op]++;
            case (req.op)
                OP_PUSH: begin
                    if (stack_fill >= STACK_DEPTH) begin
                        want.status = ST_FULL;
                        full_refusals++;
                    end else begin
                        stack_image[stack_fill] = req.value;
                        stack_fill++;
                    end
                end
                OP_POP: begin
                    if (stack_fill == 0) begin
                        want.status = ST_EMPTY;
                        empty_refusals++;
                    end else begin
                        stack_fill--;
                        want.word_out = stack_image[stack_fill];
                    end
                end
                OP_PEEK: begin
                    if (stack_fill == 0) begin
                        want.status = ST_EMPTY;
                        empty_refusals++;
                    end else begin
                        want.word_out = stack_image[stack_fill - 1];
                    end
                end
                default: begin
                    // Walk from the top down; the first match wins.
                    for (d = 0; d < stack_fill; d++) begin
                        if (!found && stack_image[stack_fill - 1 - d] == req.value) begin
                            found         = 1'b1;
                            want.position = 4'(d);
                        end
                    end
                    if (found) begin
                        search_hits++;
                    end else begin
                        want.status = ST_NOTFOUND;
                        search_misses++;
                    end
                end
            endcase
            want.is_empty   = (stack_fill == 0);
            want.fill_count = 5'(stack_fill);
            pending_results.push_back(want);
        endfunction

        function void compare_field(string field, logic [31:0] want_v, logic [31:0] got_v);
            if (got_v !== want_v) begin
                $display("%0t: %s mismatch: expected %0h, actual %0h",
                         $time, field, want_v, got_v);
                error_count++;
            end
        endfunction

        function void check_result(t_out got);
            t_out want;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual status %0d word %0h",
                         $time, got.status, got.word_out);
                error_count++;
                return;
            end
            want = pending_results.pop_front();
            result_count++;
            compare_field("status", 32'(want.status), 32'(got.status));
            compare_field("word_out", 32'(want.word_out), 32'(got.word_out));
            compare_field("position", 32'(want.position), 32'(got.position));
            compare_field("is_empty", 32'(want.is_empty), 32'(got.is_empty));
            compare_field("fill_count", 32'(want.fill_count), 32'(got.fill_count));
        endfunction
    endclass

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    logic in_stall;
    t_in  in_data   = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    t_out out_data;

    // When set, the sender offers back to back and the receiver takes
    // every result at once, giving stretches with no idling at all.
    bit tx_eager = 1'b0;
    bit rx_eager = 1'b0;
    bit backlog_requested = 1'b0;
    bit backlog_done      = 1'b0;

    stack_scoreboard sb = new();

    always #5 clk = ~clk;

    bounded_stack_with_search DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    // Both channels are observed at the clock edge: a transaction happens
    // where valid is high and stall is low. Requests go into the scoreboard
    // before results are checked, though no result can follow its own
    // request within the same edge.
    always @(posedge clk) begin
        if (rst_n && in_valid && !in_stall) begin
            sb.note_request(in_data);
        end
        if (rst_n && out_valid && !out_stall) begin
            sb.check_result(out_data);
        end
    end

    // Result side. After each accepted result it may stall for a random
    // number of cycles. Once asked, it holds the output off for a long
    // stretch so the block backs up and stalls its input.
    initial begin : result_sink
        int unsigned hold;
        forever begin
            @(posedge clk);
            if (backlog_requested && !backlog_done) begin
                out_stall <= 1'b1;
                repeat (BACKLOG_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
                backlog_done = 1'b1;
            end else if (rst_n && out_valid && !out_stall) begin
                hold = rx_eager ? 0 : $urandom_range(0, 13);
                if (hold != 0) begin
                    out_stall <= 1'b1;
                    repeat (hold) @(posedge clk);
                    out_stall <= 1'b0;
                end
            end
        end
    end

    // Offers one request after a random gap and returns once the block has
    // taken it. Valid stays high on return, so a request that follows with
    // no gap keeps it high; it is lowered only when a gap is drawn.
    task automatic send_request(input t_op op, input logic [31:0] word);
        int unsigned gap;
        t_in         req;
        gap       = tx_eager ? 0 : $urandom_range(0, 13);
        req.op    = op;
        req.value = word;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // Words lean toward the extremes and toward a few small values, so that
    // duplicates in the stack are common.
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 5))
            0: begin
                case ($urandom_range(0, 3))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            1: return 32'($signed($urandom_range(0, 8)) - 4);
            default: return $urandom;
        endcase
    endfunction

    // Most searches look for a word the stack holds. The scoreboard's image
    // may still lag the request accepted at this very edge, which at worst
    // turns an intended hit into a miss now and then.
    function automatic logic [31:0] pick_key();
        if (sb.stack_fill != 0 && $urandom_range(0, 2) != 0) begin
            return sb.stack_image[$urandom_range(0, sb.stack_fill - 1)];
        end
        return pick_word();
    endfunction

    // Filling phases favor pushes and draining phases favor pops, so the
    // stack swings between empty and full many times.
    function automatic t_op pick_op(bit filling);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return filling ? OP_PUSH : OP_POP;
        end else if (r < 65) begin
            return filling ? OP_POP : OP_PUSH;
        end else if (r < 75) begin
            return OP_PEEK;
        end
        return OP_SEARCH;
    endfunction

    task automatic send_random_request(input bit filling);
        t_op op;
        op = pick_op(filling);
        send_request(op, (op == OP_SEARCH) ? pick_key() : pick_word());
    endtask

    initial begin : stimulus
        int unsigned n;
        int unsigned k;
        bit          filling;
        filling = 1'b1;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Requests refused on an empty stack, and a search with nothing to walk.
        send_request(OP_POP, 32'h0);
        send_request(OP_PEEK, 32'h0);
        send_request(OP_SEARCH, 32'h0);
        // Extreme words, then a peek and searches that hit and miss.
        send_request(OP_PUSH, 32'h7FFF_FFFF);
        send_request(OP_PUSH, 32'h8000_0000);
        send_request(OP_PUSH, 32'h0000_0000);
        send_request(OP_PUSH, 32'hFFFF_FFFF);
        send_request(OP_PEEK, 32'h0);
        send_request(OP_SEARCH, 32'h8000_0000);
        send_request(OP_SEARCH, 32'h1234_5678);
        // A duplicate: the search must report the copy nearest the top.
        send_request(OP_PUSH, 32'hFFFF_FFFF);
        send_request(OP_SEARCH, 32'hFFFF_FFFF);
        // Fill to the brim, push once more, and search down to the bottom entry.
        for (k = 0; k < STACK_DEPTH - 5; k++) begin
            send_request(OP_PUSH, 32'h5A5A_0000 + k);
        end
        send_request(OP_PUSH, 32'hDEAD_BEEF);
        send_request(OP_SEARCH, 32'h7FFF_FFFF);
        send_request(OP_POP, 32'h0);

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 50 == 0) begin
                tx_eager = ($urandom_range(0, 3) == 0);
                rx_eager = ($urandom_range(0, 3) == 0);
                filling  = ~filling;
            end
            if (n == RANDOM_ITEMS / 2) begin
                // Hold the output off and keep offering requests back to back.
                backlog_requested = 1'b1;
                tx_eager          = 1'b1;
                for (k = 0; k < BACKLOG_ITEMS; k++) begin
                    send_random_request(filling);
                end
                tx_eager = 1'b0;
            end
            send_random_request(filling);
        end
        in_valid <= 1'b0;

        while (sb.pending_results.size() != 0) @(posedge clk);
        // A straggling result would show up within one full search.
        repeat (STACK_DEPTH + 8) @(posedge clk);

        $display("Sent %0d requests (%0d push, %0d pop, %0d peek, %0d search);",
                 sb.op_count[OP_PUSH] + sb.op_count[OP_POP] + sb.op_count[OP_PEEK]
                 + sb.op_count[OP_SEARCH], sb.op_count[OP_PUSH], sb.op_count[OP_POP],
                 sb.op_count[OP_PEEK], sb.op_count[OP_SEARCH]);
        $display("%0d results checked; refused %0d pushes when full, %0d pops or peeks",
                 sb.result_count, sb.full_refusals, sb.empty_refusals);
        $display("when empty; %0d search hits, %0d misses.",
                 sb.search_hits, sb.search_misses);
        if (sb.error_count == 0 && sb.pending_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin : watchdog
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
